// ===== rtl/spmq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spmq_pkg
// Shared types, codes and defaults of the strict priority multi-queue unit.
// ----------------------------------------------------------------------------
package spmq_pkg;

   localparam int DEF_LEVELS      = 13;
   localparam int DEF_LEVEL_DEPTH = 64;
   localparam int DEF_HANDLE_BITS = 32;

   localparam int REQ_TDATA_W = 40;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 40;
   localparam int RSP_TUSER_W = 3;

   localparam logic [1:0] CMD_DISPATCH = 2'd0;
   localparam logic [1:0] CMD_TAKE     = 2'd1;
   localparam logic [1:0] CMD_SHUTDOWN = 2'd2;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_BAD_LEVEL = 3'd1;
   localparam logic [2:0] STATUS_REJECTED  = 3'd2;
   localparam logic [2:0] STATUS_FULL      = 3'd3;
   localparam logic [2:0] STATUS_EMPTY     = 3'd4;
   localparam logic [2:0] STATUS_STOPPED   = 3'd5;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_RESP
   } state_type;

   typedef struct packed {
      logic update;
      logic take;
   } lvl_ctrl_type;

   typedef struct packed {
      logic full;
      logic pending;
   } lvl_stat_type;

endpackage : spmq_pkg
`default_nettype wire

// ===== rtl/strict_priority_multi_queue_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// strict_priority_multi_queue_unit
// Event scheduler with one FIFO per priority level and strict priority serve.
//
// Request channel (req_): tuser carries the command (dispatch, take next,
// shutdown); tdata carries level, handle and the worker flag. Each accepted
// command except the unused code yields exactly one transaction on the
// response channel (rsp_): tuser carries the status, tdata the served handle
// and level (zero unless a take next succeeded).
// A command runs through a three-step sequencer: accept, execute (pointer
// and count update in the shared level unit, store write or read issue) and
// respond (load the output register from the registered store read). A new
// command is accepted only after the current one has left the respond step;
// the unused command returns from execute straight to accept and gives no
// response.
// Reset empties every level and clears the shutdown flag; handle store
// contents are not cleared since only written entries are ever read.
// When the receiver stalls, the response is held in the output register;
// one more command is accepted and executed, then the sequencer waits in the
// respond step and accepts nothing until the output register frees.
// ----------------------------------------------------------------------------
module strict_priority_multi_queue_unit #(
   parameter int LEVELS      = spmq_pkg::DEF_LEVELS,
   parameter int LEVEL_DEPTH = spmq_pkg::DEF_LEVEL_DEPTH,
   parameter int HANDLE_BITS = spmq_pkg::DEF_HANDLE_BITS
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // level[3:0], handle[35:4], from_worker[36], zero[39:37]
   input  wire logic [spmq_pkg::REQ_TDATA_W-1:0] req_tdata,
   // command[1:0]
   input  wire logic [spmq_pkg::REQ_TUSER_W-1:0] req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // served_handle[31:0], served_level[35:32], zero[39:36]
   output logic      [spmq_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // status[2:0]
   output logic      [spmq_pkg::RSP_TUSER_W-1:0] rsp_tuser
);
   import spmq_pkg::*;

   localparam int LVL_W  = $clog2(LEVELS);
   localparam int DEPTH  = LEVELS * LEVEL_DEPTH;
   localparam int ADDR_W = $clog2(DEPTH);

   state_type state_ff, state_in;

   logic [1:0]             cmd_ff;
   logic [3:0]             level_ff;
   logic [HANDLE_BITS-1:0] handle_ff;
   logic                   worker_ff;
   logic                   stop_ff, stop_in;
   logic [2:0]             status_ff, status_in;
   logic                   take_ok_ff, take_ok_in;
   logic [LVL_W-1:0]       srv_lvl_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [2:0]             rsp_status_ff;
   logic [31:0]            rsp_handle_ff;
   logic [3:0]             rsp_level_ff;

   logic                   accept;
   logic                   load_rsp;
   logic                   has_result;
   logic                   wr_en;
   logic                   rd_en;
   logic                   is_take;
   logic [LVL_W-1:0]       sel_lvl;
   logic [LVL_W-1:0]       first_lvl;
   logic [ADDR_W-1:0]      addr;
   logic [HANDLE_BITS-1:0] rd_data;
   lvl_ctrl_type           ctl;
   lvl_stat_type           stat;

   assign accept  = req_tvalid && req_tready;
   assign is_take = (cmd_ff == CMD_TAKE);
   assign sel_lvl = is_take ? first_lvl : level_ff[LVL_W-1:0];

   spmq_levels #(
      .LEVELS      (LEVELS),
      .LEVEL_DEPTH (LEVEL_DEPTH)
   ) u_levels (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .lvl       (sel_lvl),
      .addr      (addr),
      .first_lvl (first_lvl),
      .stat      (stat)
   );

   spmq_ram #(
      .WIDTH (HANDLE_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr),
      .wr_data (handle_ff),
      .rd_en   (rd_en),
      .rd_addr (addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = has_result ? S_RESP : S_IDLE;
         end
         S_RESP: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      ctl        = '0;
      wr_en      = 1'b0;
      rd_en      = 1'b0;
      has_result = 1'b0;
      load_rsp   = 1'b0;
      stop_in    = stop_ff;
      status_in  = status_ff;
      take_ok_in = take_ok_ff;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
         end
         S_EXEC: begin
            has_result = 1'b1;
            take_ok_in = 1'b0;
            status_in  = STATUS_OK;
            case (cmd_ff)
               CMD_DISPATCH: begin
                  if ({1'b0, level_ff} >= 5'(LEVELS)) begin
                     status_in = STATUS_BAD_LEVEL;
                  end else if (stop_ff && !worker_ff) begin
                     status_in = STATUS_REJECTED;
                  end else if (stat.full) begin
                     status_in = STATUS_FULL;
                  end else begin
                     wr_en      = 1'b1;
                     ctl.update = 1'b1;
                  end
               end
               CMD_TAKE: begin
                  if (stop_ff) begin
                     status_in = STATUS_STOPPED;
                  end else if (!stat.pending) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     rd_en      = 1'b1;
                     ctl.update = 1'b1;
                     ctl.take   = 1'b1;
                     take_ok_in = 1'b1;
                  end
               end
               CMD_SHUTDOWN: begin
                  stop_in = 1'b1;
               end
               default: begin
                  has_result = 1'b0;
               end
            endcase
         end
         S_RESP: begin
            load_rsp = !rsp_valid_ff || rsp_tready;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         stop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         status_ff    <= STATUS_OK;
         take_ok_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stop_ff      <= stop_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff    <= status_in;
         take_ok_ff   <= take_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= req_tuser[1:0];
         level_ff  <= req_tdata[3:0];
         handle_ff <= HANDLE_BITS'(req_tdata[35:4]);
         worker_ff <= req_tdata[36];
      end
      if (state_ff == S_EXEC) begin
         srv_lvl_ff <= sel_lvl;
      end
      if (load_rsp) begin
         rsp_status_ff <= status_ff;
         rsp_handle_ff <= take_ok_ff ? 32'(rd_data) : 32'd0;
         rsp_level_ff  <= take_ok_ff ? 4'(srv_lvl_ff) : 4'd0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {4'd0, rsp_level_ff, rsp_handle_ff};

endmodule : strict_priority_multi_queue_unit
`default_nettype wire

// ===== rtl/spmq_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spmq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module spmq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule : spmq_ram
`default_nettype wire

// ===== rtl/spmq_levels.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spmq_levels
// Per-level head, tail and count registers with one shared pointer/count
// update unit, store address generation and lowest pending level select.
// ----------------------------------------------------------------------------
module spmq_levels #(
   parameter int LEVELS      = spmq_pkg::DEF_LEVELS,
   parameter int LEVEL_DEPTH = spmq_pkg::DEF_LEVEL_DEPTH
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire spmq_pkg::lvl_ctrl_type                 ctl,
   input  wire logic [$clog2(LEVELS)-1:0]              lvl,
   output logic [$clog2(LEVELS*LEVEL_DEPTH)-1:0]       addr,
   output logic [$clog2(LEVELS)-1:0]                   first_lvl,
   output spmq_pkg::lvl_stat_type                      stat
);
   import spmq_pkg::*;

   localparam int LVL_W  = $clog2(LEVELS);
   localparam int POS_W  = $clog2(LEVEL_DEPTH);
   localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
   localparam int ADDR_W = $clog2(LEVELS * LEVEL_DEPTH);

   logic [POS_W-1:0] head_ff  [LEVELS];
   logic [POS_W-1:0] head_in  [LEVELS];
   logic [POS_W-1:0] tail_ff  [LEVELS];
   logic [POS_W-1:0] tail_in  [LEVELS];
   logic [CNT_W-1:0] count_ff [LEVELS];
   logic [CNT_W-1:0] count_in [LEVELS];

   logic [POS_W-1:0] pos_sel;
   logic [POS_W-1:0] pos_next;
   logic [CNT_W-1:0] cnt_sel;
   logic [CNT_W-1:0] cnt_next;

   assign pos_sel  = ctl.take ? head_ff[lvl] : tail_ff[lvl];
   assign pos_next = (pos_sel == POS_W'(LEVEL_DEPTH - 1)) ? '0 : pos_sel + 1'b1;
   assign cnt_sel  = count_ff[lvl];
   assign cnt_next = ctl.take ? cnt_sel - 1'b1 : cnt_sel + 1'b1;
   assign addr     = ADDR_W'(ADDR_W'(lvl) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(pos_sel));

   always_comb begin
      first_lvl    = '0;
      stat.full    = (cnt_sel == CNT_W'(LEVEL_DEPTH));
      stat.pending = 1'b0;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (count_ff[i] != '0) begin
            first_lvl    = LVL_W'(i);
            stat.pending = 1'b1;
         end
      end
   end

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (ctl.update) begin
         count_in[lvl] = cnt_next;
         if (ctl.take) begin
            head_in[lvl] = pos_next;
         end else begin
            tail_in[lvl] = pos_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LEVELS; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

endmodule : spmq_levels
`default_nettype wire

// ===== rtl/spmq_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spmq_checker
// Port-level checks of the strict priority multi-queue unit, bound to the top.
// ----------------------------------------------------------------------------
module spmq_checker #(
   parameter int LEVELS = spmq_pkg::DEF_LEVELS
) (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_tvalid,
   input wire logic                             req_tready,
   input wire logic [spmq_pkg::REQ_TDATA_W-1:0] req_tdata,
   input wire logic [spmq_pkg::REQ_TUSER_W-1:0] req_tuser,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [spmq_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic [spmq_pkg::RSP_TUSER_W-1:0] rsp_tuser
);
   import spmq_pkg::*;

   // hold a stalled response transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // drop ready while a command executes
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted during execution");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= STATUS_STOPPED)
      else $error("undefined status code");

   a_fail_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STATUS_OK |-> rsp_tdata == '0)
      else $error("failed transaction carries data");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> {1'b0, rsp_tdata[35:32]} < 5'(LEVELS))
      else $error("served level out of range");

endmodule : spmq_checker

bind strict_priority_multi_queue_unit spmq_checker #(.LEVELS(LEVELS)) u_spmq_checker (.*);
`default_nettype wire

// ===== tb/sv/strict_priority_multi_queue_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strict_priority_multi_queue_unit_tb
// Self-checking bench for the strict priority scheduler. A table of opening
// commands covers the empty, bad level and priority order cases. Random
// bursts then fill levels to full, drain them past empty and mix in noise,
// under three idle patterns on the two channels. A closing table requests
// shutdown and probes the stopped and rejected paths; worker dispatches
// follow. Each response is checked field by field against an in-bench
// scheduler that tracks every level FIFO.
// ----------------------------------------------------------------------------
module strict_priority_multi_queue_unit_tb;
   import spmq_pkg::*;

   localparam logic [1:0] CMD_UNUSED  = 2'd3;
   localparam int unsigned CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [1:0]                 command;
      logic [3:0]                 level;
      logic [DEF_HANDLE_BITS-1:0] handle;
      logic                       worker;
   } sched_cmd_type;

   typedef struct packed {
      logic [2:0]                 status;
      logic [DEF_HANDLE_BITS-1:0] served_handle;
      logic [3:0]                 served_level;
   } sched_rsp_type;

   typedef struct packed {
      logic [1:0]                 command;
      logic [3:0]                 level;
      logic [DEF_HANDLE_BITS-1:0] handle;
      logic                       worker;
      logic                       typed;
      logic [2:0]                 status;
      logic [DEF_HANDLE_BITS-1:0] served_handle;
      logic [3:0]                 served_level;
   } cmd_row_type;

   // command, level, handle, worker, typed, status, served_handle, served_level
   cmd_row_type opening_rows [18] = '{
      '{CMD_TAKE,     4'd0,  32'h0000_0000, 1'b0, 1'b1, STATUS_EMPTY,     32'h0000_0000, 4'd0},
      '{CMD_DISPATCH, 4'd0,  32'h0000_0000, 1'b0, 1'b1, STATUS_OK,        32'h0000_0000, 4'd0},
      '{CMD_DISPATCH, 4'd12, 32'hffff_ffff, 1'b1, 1'b1, STATUS_OK,        32'h0000_0000, 4'd0},
      '{CMD_DISPATCH, 4'd13, 32'h1234_5678, 1'b0, 1'b1, STATUS_BAD_LEVEL, 32'h0000_0000, 4'd0},
      '{CMD_DISPATCH, 4'd15, 32'hffff_ffff, 1'b1, 1'b1, STATUS_BAD_LEVEL, 32'h0000_0000, 4'd0},
      '{CMD_DISPATCH, 4'd5,  32'ha5a5_a5a5, 1'b0, 1'b0, STATUS_OK,        32'h0000_0000, 4'd0},
      '{CMD_DISPATCH, 4'd5,  32'h5a5a_5a5a, 1'b1, 1'b0, STATUS_OK,        32'h0000_0000, 4'd0},
      '{CMD_DISPATCH, 4'd0,  32'h1234_5678, 1'b0, 1'b0, STATUS_OK,        32'h0000_0000, 4'd0},
      '{CMD_TAKE,     4'd0,  32'h0000_0000, 1'b0, 1'b1, STATUS_OK,        32'h0000_0000, 4'd0},
      '{CMD_TAKE,     4'd0,  32'h0000_0000, 1'b0, 1'b1, STATUS_OK,        32'h1234_5678, 4'd0},
      '{CMD_TAKE,     4'd0,  32'h0000_0000, 1'b0, 1'b0, STATUS_OK,        32'h0000_0000, 4'd0},
      '{CMD_TAKE,     4'd9,  32'hffff_ffff, 1'b1, 1'b0, STATUS_OK,        32'h0000_0000, 4'd0},
      '{CMD_TAKE,     4'd0,  32'h0000_0000, 1'b0, 1'b1, STATUS_OK,        32'hffff_ffff, 4'd12},
      '{CMD_TAKE,     4'd0,  32'h0000_0000, 1'b0, 1'b1, STATUS_EMPTY,     32'h0000_0000, 4'd0},
      '{CMD_UNUSED,   4'd15, 32'hffff_ffff, 1'b1, 1'b0, STATUS_OK,        32'h0000_0000, 4'd0},
      '{CMD_DISPATCH, 4'd7,  32'h8000_0001, 1'b0, 1'b0, STATUS_OK,        32'h0000_0000, 4'd0},
      '{CMD_DISPATCH, 4'd3,  32'h7fff_fffe, 1'b1, 1'b0, STATUS_OK,        32'h0000_0000, 4'd0},
      '{CMD_TAKE,     4'd0,  32'h0000_0000, 1'b0, 1'b1, STATUS_OK,        32'h7fff_fffe, 4'd3}
   };

   cmd_row_type closing_rows [11] = '{
      '{CMD_DISPATCH, 4'd4,  32'hdead_beef, 1'b0, 1'b0, STATUS_OK,        32'h0000_0000, 4'd0},
      '{CMD_TAKE,     4'd0,  32'h0000_0000, 1'b0, 1'b0, STATUS_OK,        32'h0000_0000, 4'd0},
      '{CMD_SHUTDOWN, 4'd0,  32'h0000_0000, 1'b0, 1'b1, STATUS_OK,        32'h0000_0000, 4'd0},
      '{CMD_SHUTDOWN, 4'd15, 32'hffff_ffff, 1'b1, 1'b1, STATUS_OK,        32'h0000_0000, 4'd0},
      '{CMD_TAKE,     4'd0,  32'h0000_0000, 1'b0, 1'b1, STATUS_STOPPED,   32'h0000_0000, 4'd0},
      '{CMD_DISPATCH, 4'd2,  32'h0bad_cafe, 1'b0, 1'b1, STATUS_REJECTED,  32'h0000_0000, 4'd0},
      '{CMD_DISPATCH, 4'd15, 32'h0bad_cafe, 1'b0, 1'b1, STATUS_BAD_LEVEL, 32'h0000_0000, 4'd0},
      '{CMD_DISPATCH, 4'd13, 32'hffff_ffff, 1'b1, 1'b1, STATUS_BAD_LEVEL, 32'h0000_0000, 4'd0},
      '{CMD_DISPATCH, 4'd2,  32'h600d_f00d, 1'b1, 1'b0, STATUS_OK,        32'h0000_0000, 4'd0},
      '{CMD_UNUSED,   4'd0,  32'h0000_0000, 1'b0, 1'b0, STATUS_OK,        32'h0000_0000, 4'd0},
      '{CMD_TAKE,     4'd0,  32'h0000_0000, 1'b0, 1'b1, STATUS_STOPPED,   32'h0000_0000, 4'd0}
   };

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;

   // scheduler state as seen from outside
   logic [DEF_HANDLE_BITS-1:0] held_handles [DEF_LEVELS][DEF_LEVEL_DEPTH];
   int unsigned                rd_pos       [DEF_LEVELS];
   int unsigned                wr_pos       [DEF_LEVELS];
   int unsigned                held_count   [DEF_LEVELS];
   int unsigned                held_total   = 0;
   bit                         shut_down    = 1'b0;

   sched_rsp_type due_responses [$];
   sched_rsp_type oldest_due;
   int unsigned   mismatches  = 0;
   int unsigned   issued_count = 0;
   int unsigned   cycle_count = 0;
   int unsigned   tx_idle_pct = 0;
   int unsigned   rx_idle_pct = 0;

   strict_priority_multi_queue_unit #(
      .LEVELS      (DEF_LEVELS),
      .LEVEL_DEPTH (DEF_LEVEL_DEPTH),
      .HANDLE_BITS (DEF_HANDLE_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic schedule_command(input sched_cmd_type c, output bit produces,
                                   output sched_rsp_type r);
      int unsigned lvl;
      bit          found;
      r        = '0;
      produces = 1'b1;
      found    = 1'b0;
      case (c.command)
         CMD_DISPATCH: begin
            if (c.level >= DEF_LEVELS) begin
               r.status = STATUS_BAD_LEVEL;
            end else if (shut_down && !c.worker) begin
               r.status = STATUS_REJECTED;
            end else if (held_count[c.level] >= DEF_LEVEL_DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               held_handles[c.level][wr_pos[c.level]] = c.handle;
               wr_pos[c.level]     = (wr_pos[c.level] + 1) % DEF_LEVEL_DEPTH;
               held_count[c.level] = held_count[c.level] + 1;
               held_total          = held_total + 1;
               r.status            = STATUS_OK;
            end
         end
         CMD_TAKE: begin
            if (shut_down) begin
               r.status = STATUS_STOPPED;
            end else begin
               r.status = STATUS_EMPTY;
               for (lvl = 0; lvl < DEF_LEVELS && !found; lvl++) begin
                  if (held_count[lvl] != 0) begin
                     found           = 1'b1;
                     r.status        = STATUS_OK;
                     r.served_handle = held_handles[lvl][rd_pos[lvl]];
                     r.served_level  = lvl[3:0];
                     rd_pos[lvl]     = (rd_pos[lvl] + 1) % DEF_LEVEL_DEPTH;
                     held_count[lvl] = held_count[lvl] - 1;
                     held_total      = held_total - 1;
                  end
               end
            end
         end
         CMD_SHUTDOWN: begin
            shut_down = 1'b1;
            r.status  = STATUS_OK;
         end
         default: begin
            produces = 1'b0;
         end
      endcase
   endtask

   task automatic send_command(input sched_cmd_type c, input bit typed,
                               input sched_rsp_type typed_rsp);
      bit            produces;
      sched_rsp_type predicted;
      if ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < tx_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= c.command;
      req_tdata  <= {3'b000, c.worker, c.handle, c.level};
      do @(posedge clock); while (!req_tready);
      schedule_command(c, produces, predicted);
      if (produces) begin
         due_responses.push_back(typed ? typed_rsp : predicted);
      end
      if (c.command != CMD_UNUSED) begin
         issued_count = issued_count + 1;
      end
   endtask

   task automatic play_row(input cmd_row_type row);
      sched_cmd_type c;
      sched_rsp_type r;
      c.command       = row.command;
      c.level         = row.level;
      c.handle        = row.handle;
      c.worker        = row.worker;
      r.status        = row.status;
      r.served_handle = row.served_handle;
      r.served_level  = row.served_level;
      send_command(c, row.typed, r);
   endtask

   function automatic logic [DEF_HANDLE_BITS-1:0] random_handle();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic sched_cmd_type make_cmd(input logic [1:0] command,
                                              input int unsigned lvl,
                                              input int unsigned worker_pct);
      sched_cmd_type c;
      c.command = command;
      c.level   = lvl[3:0];
      c.handle  = random_handle();
      c.worker  = ($urandom_range(0, 99) < worker_pct);
      return c;
   endfunction

   task automatic mixed_item(input int unsigned worker_pct);
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 46) begin
         send_command(make_cmd(CMD_DISPATCH, $urandom_range(0, DEF_LEVELS - 1), worker_pct),
                      1'b0, '0);
      end else if (pick < 50) begin
         send_command(make_cmd(CMD_DISPATCH, $urandom_range(DEF_LEVELS, 15), worker_pct),
                      1'b0, '0);
      end else if (pick < 96) begin
         send_command(make_cmd(CMD_TAKE, $urandom_range(0, 15), worker_pct), 1'b0, '0);
      end else begin
         send_command(make_cmd(CMD_UNUSED, $urandom_range(0, 15), worker_pct), 1'b0, '0);
      end
   endtask

   task automatic fill_level(input int unsigned lvl, input int unsigned count,
                             input int unsigned worker_pct);
      repeat (count) send_command(make_cmd(CMD_DISPATCH, lvl, worker_pct), 1'b0, '0);
   endtask

   task automatic take_burst(input int unsigned count);
      repeat (count) send_command(make_cmd(CMD_TAKE, 0, 50), 1'b0, '0);
   endtask

   task automatic hold_until_settled();
      if (due_responses.size() != 0) begin
         req_tvalid <= 1'b0;
         while (due_responses.size() != 0) @(posedge clock);
      end
   endtask

   task automatic run_phase(input int unsigned tx_pct, input int unsigned rx_pct,
                            input int unsigned count);
      int unsigned start;
      int unsigned len;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      start       = issued_count;
      fill_level($urandom_range(0, DEF_LEVELS - 1), DEF_LEVEL_DEPTH + $urandom_range(2, 6), 50);
      while (issued_count - start < count) begin
         len = $urandom_range(4, 32);
         case ($urandom_range(0, 9))
            0, 1, 2, 3: repeat (len) mixed_item(50);
            4: fill_level($urandom_range(0, DEF_LEVELS - 1), len, 50);
            5: fill_level($urandom_range(0, DEF_LEVELS - 1), DEF_LEVEL_DEPTH + 3, 50);
            6: take_burst(len);
            7: begin
               // drain everything, then hit the empty case
               take_burst(held_total + $urandom_range(1, 3));
            end
            8: begin
               hold_until_settled();
               repeat (len) mixed_item(50);
            end
            default: begin
               take_burst(len / 2);
               repeat (len) mixed_item(50);
            end
         endcase
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (due_responses.size() == 0) begin
               $error("response with no command waiting: status %0d", rsp_tuser);
               mismatches = mismatches + 1;
            end else begin
               oldest_due = due_responses.pop_front();
               if (rsp_tuser !== oldest_due.status) begin
                  $error("status: expected %0d, actual %0d", oldest_due.status, rsp_tuser);
                  mismatches = mismatches + 1;
               end
               if (rsp_tdata[31:0] !== oldest_due.served_handle) begin
                  $error("served_handle: expected %h, actual %h",
                         oldest_due.served_handle, rsp_tdata[31:0]);
                  mismatches = mismatches + 1;
               end
               if (rsp_tdata[35:32] !== oldest_due.served_level) begin
                  $error("served_level: expected %0d, actual %0d",
                         oldest_due.served_level, rsp_tdata[35:32]);
                  mismatches = mismatches + 1;
               end
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   initial begin
      for (int i = 0; i < DEF_LEVELS; i++) begin
         rd_pos[i]     = 0;
         wr_pos[i]     = 0;
         held_count[i] = 0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      tx_idle_pct = 28;
      rx_idle_pct = 64;
      foreach (opening_rows[i]) play_row(opening_rows[i]);

      run_phase(28, 64, 280);
      hold_until_settled();
      run_phase(64, 28, 280);
      hold_until_settled();
      run_phase(0, 0, 280);

      // shutdown is sticky, so its cases close the run
      foreach (closing_rows[i]) play_row(closing_rows[i]);
      fill_level(DEF_LEVELS - 1, DEF_LEVEL_DEPTH + 4, 100);
      repeat (60) mixed_item(75);

      req_tvalid <= 1'b0;
      while (due_responses.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule : strict_priority_multi_queue_unit_tb
